/* hdl/b2da_pkg.sv */
// shared types and constants for the binary to decimal ascii formatter
`default_nettype none
package b2da_pkg;

    // word and digit sizes
    localparam int BIN_WIDTH  = 16;
    localparam int NUM_DIGITS = 5;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;
    localparam int BIT_CNT_W  = $clog2(BIN_WIDTH);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    // ascii codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    // per cycle command to every digit cell
    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift_digit;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* hdl/b2da_digit_cell.sv */
// one bcd digit cell: shift-add-3 step and digit-wide shift toward the top
`default_nettype none
module b2da_digit_cell (
    input  wire logic                          clk,
    input  wire b2da_pkg::cell_ctrl_t          ctrl,
    input  wire logic                          bit_in,
    input  wire logic [b2da_pkg::DIGIT_W-1:0]  digit_in,
    output logic                               bit_out,
    output logic [b2da_pkg::DIGIT_W-1:0]       digit
);
    import b2da_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    // add 3 when the digit would overflow on the next doubling
    always_comb
    begin
        adj = (digit_reg >= DIGIT_W'(5)) ? (digit_reg + DIGIT_W'(3)) : digit_reg;
    end

    assign bit_out = adj[DIGIT_W-1];
    assign digit   = digit_reg;

    // next digit value
    always_comb
    begin
        priority if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[DIGIT_W-2:0], bit_in};
        end
        else if (ctrl.shift_digit)
        begin
            digit_next = digit_in;
        end
        else
        begin
            digit_next = digit_reg;
        end
    end

    // digit register
    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule
`default_nettype wire

/* hdl/b2da_cell_chain.sv */
// row of bcd digit cells, ones digit at index 0, top digit at the far end
`default_nettype none
module b2da_cell_chain (
    input  wire logic                          clk,
    input  wire b2da_pkg::cell_ctrl_t          ctrl,
    input  wire logic                          serial_bit,
    output logic [b2da_pkg::DIGIT_W-1:0]       top_digit
);
    import b2da_pkg::*;

    logic [NUM_DIGITS-1:0] bit_in;
    logic [NUM_DIGITS-1:0] bit_out;
    logic [DIGIT_W-1:0]    digit_in [NUM_DIGITS];
    logic [DIGIT_W-1:0]    digit    [NUM_DIGITS];

    // neighbor links: bits ripple up during conversion, digits move up during output
    assign bit_in[0]   = serial_bit;
    assign digit_in[0] = '0;

    for (genvar i = 1; i < NUM_DIGITS; i++)
    begin : g_link
        assign bit_in[i]   = bit_out[i-1];
        assign digit_in[i] = digit[i-1];
    end

    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        b2da_digit_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .bit_in   (bit_in[i]),
            .digit_in (digit_in[i]),
            .bit_out  (bit_out[i]),
            .digit    (digit[i])
        );
    end

    assign top_digit = digit[NUM_DIGITS-1];

endmodule
`default_nettype wire

/* hdl/binary_to_decimal_ascii_top.sv */
// top level: 16-bit word to decimal ascii text, one character per beat
//
//  channel   handshake                 payload
//  item      item_valid / item_ready   func, value
//  char      char_valid / char_ready   character, last
//
// a word is taken only while the controller is idle; the last character may still wait
// conversion shifts the 16 input bits through the digit cell row, one input bit per cycle
// output then walks 5 digit positions, one per cycle unless char_ready holds a beat, after a minus sign if negative
// a low char_ready stalls the controller at the next beat to send; leading zeros still move
// reset clears the controller and the output valid flag
`default_nettype none
module binary_to_decimal_ascii_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire logic                          func,
    input  wire logic [b2da_pkg::BIN_WIDTH-1:0] value,
    output logic                               char_valid,
    input  wire logic                          char_ready,
    output logic [b2da_pkg::CHAR_W-1:0]        character,
    output logic                               last
);
    import b2da_pkg::*;

    state_t                 state_reg,     state_next;
    logic [BIN_WIDTH-1:0]   shift_reg,     shift_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg,   bit_cnt_next;
    logic [DIG_CNT_W-1:0]   dig_cnt_reg,   dig_cnt_next;
    logic                   started_reg,   started_next;
    logic                   neg_reg,       neg_next;
    logic                   char_valid_reg, char_valid_next;
    logic [CHAR_W-1:0]      character_reg, character_next;
    logic                   last_reg,      last_next;

    cell_ctrl_t             ctrl;
    logic [DIGIT_W-1:0]     top_digit;
    logic [BIN_WIDTH-1:0]   magnitude;
    logic                   out_free;
    logic                   show;

    // digit cell row
    b2da_cell_chain u_chain (
        .clk        (clk),
        .ctrl       (ctrl),
        .serial_bit (shift_reg[BIN_WIDTH-1]),
        .top_digit  (top_digit)
    );

    // magnitude of the incoming word, most negative value fits unsigned
    assign magnitude = (func && value[BIN_WIDTH-1]) ? (~value + BIN_WIDTH'(1)) : value;

    assign out_free = !char_valid_reg || char_ready;
    assign show     = started_reg || (top_digit != '0) || (dig_cnt_reg == DIG_CNT_W'(1));

    // next state and outputs
    always_comb
    begin
        state_next      = state_reg;
        shift_next      = shift_reg;
        bit_cnt_next    = bit_cnt_reg;
        dig_cnt_next    = dig_cnt_reg;
        started_next    = started_reg;
        neg_next        = neg_reg;
        char_valid_next = char_valid_reg && !char_ready;
        character_next  = character_reg;
        last_next       = last_reg;
        ctrl            = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    shift_next   = magnitude;
                    neg_next     = func && value[BIN_WIDTH-1];
                    bit_cnt_next = BIT_CNT_W'(BIN_WIDTH - 1);
                    ctrl.clear   = 1'b1;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                ctrl.dabble  = 1'b1;
                shift_next   = {shift_reg[BIN_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DIG_CNT_W'(NUM_DIGITS);
                    started_next = 1'b0;
                    state_next   = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    char_valid_next = 1'b1;
                    character_next  = CHAR_MINUS;
                    last_next       = 1'b0;
                    state_next      = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // leading zeros move through without a beat
                if (!show || out_free)
                begin
                    ctrl.shift_digit = 1'b1;
                    dig_cnt_next     = dig_cnt_reg - DIG_CNT_W'(1);
                    if (show)
                    begin
                        char_valid_next = 1'b1;
                        character_next  = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
                        last_next       = (dig_cnt_reg == DIG_CNT_W'(1));
                        started_next    = 1'b1;
                    end
                    if (dig_cnt_reg == DIG_CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            char_valid_reg <= 1'b0;
            bit_cnt_reg    <= '0;
            dig_cnt_reg    <= '0;
            started_reg    <= 1'b0;
            neg_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            char_valid_reg <= char_valid_next;
            bit_cnt_reg    <= bit_cnt_next;
            dig_cnt_reg    <= dig_cnt_next;
            started_reg    <= started_next;
            neg_reg        <= neg_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        shift_reg     <= shift_next;
        character_reg <= character_next;
        last_reg      <= last_next;
    end

    assign item_ready = (state_reg == ST_IDLE);
    assign char_valid = char_valid_reg;
    assign character  = character_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == ST_CONV))
        else $error("accepted word did not start conversion");

    a_conv_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV && bit_cnt_reg == '0) |=>
        (state_reg == ST_SIGN || state_reg == ST_EMIT))
        else $error("conversion did not hand over to output");

    a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (dig_cnt_reg != '0))
        else $error("digit count ran out during output");

    a_digit_is_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (top_digit <= DIGIT_W'(9)))
        else $error("top cell holds a non-decimal digit");
`endif

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// testbench for the 16-bit binary to decimal ascii formatter: directed, random and stall tests
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import b2da_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int unsigned DECADE [NUM_DIGITS] = '{10000, 1000, 100, 10, 1};

    // one character of decimal text as it leaves the block
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } text_char_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_ready;
    logic                 func = 1'b0;
    logic [BIN_WIDTH-1:0] value = '0;
    logic                 char_valid;
    logic                 char_ready = 1'b0;
    logic [CHAR_W-1:0]    character;
    logic                 last;

    text_char_t expected_text[$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         hold_cycles = 0;
    int         cycle_count = 0;
    int         errors = 0;
    int         words_sent = 0;
    int         negatives_sent = 0;
    int         chars_checked = 0;

    binary_to_decimal_ascii_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .func       (func),
        .value      (value),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .character  (character),
        .last       (last)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // decimal text of one word, most significant digit first
    function automatic void predict_decimal_text(input logic is_signed,
                                                 input logic [BIN_WIDTH-1:0] word);
        logic [BIN_WIDTH:0] magnitude;
        int unsigned        digit;
        logic               leading;
        text_char_t         ch;
        magnitude = {1'b0, word};
        leading = 1'b1;
        // negative signed word: minus sign, magnitude at 17 bits covers -32768
        if (is_signed && word[BIN_WIDTH-1])
        begin
            magnitude = 17'h10000 - {1'b0, word};
            ch.character = CHAR_MINUS;
            ch.last = 1'b0;
            expected_text.push_back(ch);
            negatives_sent++;
        end
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            digit = magnitude / DECADE[i];
            magnitude = (BIN_WIDTH+1)'(magnitude % DECADE[i]);
            if (digit != 0 || !leading || i == NUM_DIGITS - 1)
            begin
                leading = 1'b0;
                ch.character = CHAR_ZERO + CHAR_W'(digit);
                ch.last = (i == NUM_DIGITS - 1);
                expected_text.push_back(ch);
            end
        end
    endfunction

    // random word, weighted toward digit-count edges and sign edges
    function automatic logic [BIN_WIDTH-1:0] pick_word();
        int unsigned p;
        p = DECADE[$urandom_range(NUM_DIGITS - 1)];
        case ($urandom_range(5))
            0: return BIN_WIDTH'($urandom_range(99));
            1: return BIN_WIDTH'(p + $urandom_range(2) - 1);
            2: return BIN_WIDTH'(17'h10000 - p - $urandom_range(1));
            3: return BIN_WIDTH'(16'h8000 + $urandom_range(2) - 1);
            default: return BIN_WIDTH'($urandom());
        endcase
    endfunction

    // offer one word, leave valid high on return so back-to-back beats stay clean
    task automatic send_word(input logic is_signed, input logic [BIN_WIDTH-1:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        func <= is_signed;
        value <= word;
        do
            @(posedge clk);
        while (!item_ready);
        predict_decimal_text(is_signed, word);
        words_sent++;
    endtask

    // sender pauses until every expected character has come
    task automatic wait_text_drained();
        item_valid <= 1'b0;
        while (expected_text.size() != 0)
            @(posedge clk);
    endtask

    // extremes, exact powers of ten and the most negative signed word
    task automatic run_directed_words();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_word(1'b0, 16'd0);
        send_word(1'b0, 16'd1);
        send_word(1'b0, 16'd9);
        send_word(1'b0, 16'd10);
        send_word(1'b0, 16'd99);
        send_word(1'b0, 16'd100);
        send_word(1'b0, 16'd1000);
        send_word(1'b0, 16'd9999);
        send_word(1'b0, 16'd10000);
        send_word(1'b0, 16'd32768);
        send_word(1'b0, 16'd65535);
        send_word(1'b1, 16'd0);
        send_word(1'b1, 16'd1);
        send_word(1'b1, 16'd10000);
        send_word(1'b1, 16'h7FFF);
        send_word(1'b1, 16'h8000);
        send_word(1'b1, 16'h8001);
        send_word(1'b1, 16'hFFFF);
        send_word(1'b1, 16'hFFF6);
        send_word(1'b1, 16'hD8F0);
        send_word(1'b1, 16'hFC18);
        send_word(1'b1, 16'hAAAA);
        send_word(1'b0, 16'h5555);
        wait_text_drained();
    endtask

    // random words under one idle setting
    task automatic run_random_words(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count)
            send_word(1'($urandom()), pick_word());
        wait_text_drained();
    endtask

    // receiver holds off a long stretch while the sender keeps offering
    task automatic run_output_hold();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles <= 300;
        repeat (20)
            send_word(1'($urandom()), pick_word());
        wait_text_drained();
    endtask

    // receiver ready, with random stalls or a counted hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            char_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            char_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each character beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && char_valid && char_ready)
        begin
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected character beat 0x%02h last %0b",
                         $time, character, last);
                errors++;
            end
            else
            begin
                text_char_t want;
                want = expected_text.pop_front();
                chars_checked++;
                if (character !== want.character)
                begin
                    $display("%0t: character mismatch expected 0x%02h actual 0x%02h",
                             $time, want.character, character);
                    errors++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last mismatch expected %0b actual %0b",
                             $time, want.last, last);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d characters outstanding",
                     cycle_count, expected_text.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed_words();
        run_random_words(85, 0, 0);
        run_output_hold();
        run_random_words(85, 86, 0);
        run_random_words(85, 0, 86);
        run_random_words(85, 14, 14);
        // settle, then catch any stray beat
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (expected_text.size() != 0)
        begin
            $display("%0t: %0d expected characters never arrived", $time, expected_text.size());
            errors++;
        end
        $display("covered %0d words (%0d negative) and %0d characters", words_sent,
                 negatives_sent, chars_checked);
        $display("idle mixes: none, sender, receiver, both, plus a long output hold-off");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
